// ===== design/poa_pkg.sv =====
`timescale 1ns / 1ps
// poa_pkg: shared constants for the planar odometer accumulator
// no dependencies

package poa_pkg;

    // the square root retires one result bit per step, taking two radicand bits
    localparam int unsigned SQRT_DIGIT_W = 2;

    // low bits appended to the partial root to form the trial subtrahend (4*r + 1)
    localparam logic [SQRT_DIGIT_W-1:0] TRIAL_SUFFIX = 2'b01;

endpackage

// ===== design/planar_odometer_accumulator_top.sv =====
`timescale 1ns / 1ps
// planar_odometer_accumulator_top: euclidean path-length accumulator
// depends on poa_pkg (square root digit constants)
//
//  channel | ports                                  | direction | handshake
//  --------+----------------------------------------+-----------+---------------
//  input   | s_x_pos, s_y_pos                       | in        | s_valid/s_ready
//  result  | m_path_total, m_saturated              | out       | m_valid/m_ready
//
// one transaction runs through an accept step, two passes through the shared squarer,
// one add, POS_WIDTH + 1 steps of the bit-serial square root and one accumulate
// step, in that order; the root loop is by far the longest part of a transaction.
// s_ready is high only while the sequencer is idle; a finished total may still wait
// on m_ready while the next transaction is taken in, and the accumulate step waits
// until the output register is free. aresetn clears the position, total and flags.

module planar_odometer_accumulator_top
    import poa_pkg::*;
#(
    parameter int unsigned POS_WIDTH = 24,
    parameter int unsigned SUM_WIDTH = 40
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [POS_WIDTH-1:0] s_x_pos,
    input  logic signed [POS_WIDTH-1:0] s_y_pos,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic        [SUM_WIDTH-1:0] m_path_total,
    output logic                        m_saturated
);

    localparam int unsigned RW    = POS_WIDTH + 1;            // root width
    localparam int unsigned NW    = SQRT_DIGIT_W * RW;        // radicand width
    localparam int unsigned PW    = 2 * POS_WIDTH;            // square width
    localparam int unsigned REM_W = RW + 3;                   // remainder width
    localparam int unsigned CW    = $clog2(RW);
    localparam int unsigned AW    = ((SUM_WIDTH > RW) ? SUM_WIDTH : RW) + 1;
    localparam logic [SUM_WIDTH-1:0] SUM_MAX = '1;
    localparam logic [CW-1:0]        LAST_STEP = CW'(RW - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQX,
        ST_SQY,
        ST_SUM,
        ST_ROOT,
        ST_ACC
    } state_t;

    state_t                 state_reg, state_next;
    logic [POS_WIDTH-1:0]   prev_x_reg, prev_y_reg;
    logic                   first_pending_reg;
    logic [POS_WIDTH-1:0]   dx_reg, dy_reg;
    logic [PW-1:0]          prod_reg;
    logic [NW-1:0]          rad_reg;
    logic [REM_W-1:0]       rem_reg;
    logic [RW-1:0]          root_reg;
    logic [CW-1:0]          step_reg;
    logic [SUM_WIDTH-1:0]   sum_reg;
    logic                   sat_reg;
    logic                   m_valid_reg;

    // absolute differences against the stored position (origin on the first fix)
    logic [POS_WIDTH-1:0] ref_x, ref_y;
    logic [POS_WIDTH:0]   diff_x, diff_y, mag_x, mag_y;

    assign ref_x  = first_pending_reg ? '0 : prev_x_reg;
    assign ref_y  = first_pending_reg ? '0 : prev_y_reg;
    assign diff_x = {s_x_pos[POS_WIDTH-1], s_x_pos} - {ref_x[POS_WIDTH-1], ref_x};
    assign diff_y = {s_y_pos[POS_WIDTH-1], s_y_pos} - {ref_y[POS_WIDTH-1], ref_y};
    assign mag_x  = diff_x[POS_WIDTH] ? (~diff_x + (POS_WIDTH+1)'(1)) : diff_x;
    assign mag_y  = diff_y[POS_WIDTH] ? (~diff_y + (POS_WIDTH+1)'(1)) : diff_y;

    // shared squarer
    logic [POS_WIDTH-1:0] mul_op;
    logic [PW-1:0]        mul_res;

    assign mul_op  = (state_reg == ST_SQX) ? dx_reg : dy_reg;
    assign mul_res = PW'(mul_op) * PW'(mul_op);

    // one restoring square root step
    logic [REM_W-1:0] rem_shift, trial, rem_diff;
    logic             take_bit;

    assign rem_shift = {rem_reg[REM_W-SQRT_DIGIT_W-1:0], rad_reg[NW-1 -: SQRT_DIGIT_W]};
    assign trial     = {1'b0, root_reg, TRIAL_SUFFIX};
    assign take_bit  = (rem_shift >= trial);
    assign rem_diff  = rem_shift - trial;

    // saturating accumulate
    logic [AW-1:0] add_wide;
    logic          add_over;

    assign add_wide = AW'(sum_reg) + AW'(root_reg);
    assign add_over = (add_wide > AW'(SUM_MAX));

    // result register loads on the accumulate step once the previous total is taken
    logic acc_fire;

    assign acc_fire = (state_reg == ST_ACC) && (!m_valid_reg || m_ready);

    // sequencer next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_valid) state_next = ST_SQX;
            ST_SQX:  state_next = ST_SQY;
            ST_SQY:  state_next = ST_SUM;
            ST_SUM:  state_next = ST_ROOT;
            ST_ROOT: if (step_reg == LAST_STEP) state_next = ST_ACC;
            ST_ACC:  if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // state and datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            prev_x_reg        <= '0;
            prev_y_reg        <= '0;
            first_pending_reg <= 1'b1;
            sum_reg           <= '0;
            sat_reg           <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (m_valid_reg && m_ready && !acc_fire) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        dx_reg            <= mag_x[POS_WIDTH-1:0];
                        dy_reg            <= mag_y[POS_WIDTH-1:0];
                        prev_x_reg        <= s_x_pos;
                        prev_y_reg        <= s_y_pos;
                        first_pending_reg <= 1'b0;
                    end
                end
                ST_SQX: begin
                    prod_reg <= mul_res;
                end
                ST_SQY: begin
                    rad_reg  <= NW'(prod_reg);
                    prod_reg <= mul_res;
                end
                ST_SUM: begin
                    rad_reg  <= rad_reg + NW'(prod_reg);
                    rem_reg  <= '0;
                    root_reg <= '0;
                    step_reg <= '0;
                end
                ST_ROOT: begin
                    rad_reg  <= rad_reg << SQRT_DIGIT_W;
                    rem_reg  <= take_bit ? rem_diff : rem_shift;
                    root_reg <= {root_reg[RW-2:0], take_bit};
                    step_reg <= step_reg + CW'(1);
                end
                ST_ACC: begin
                    if (acc_fire) begin
                        sum_reg     <= add_over ? SUM_MAX : add_wide[SUM_WIDTH-1:0];
                        sat_reg     <= add_over || (add_wide == AW'(SUM_MAX));
                        m_valid_reg <= 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_path_total = sum_reg;
    assign m_saturated  = sat_reg;

`ifndef SYNTH
    // saturation flag only ever accompanies the maximum total
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_saturated |-> (m_path_total == SUM_MAX))
        else $error("saturated flag without maximum total");

    // sequencer drops ready right after taking a transaction
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("ready held after accept");

    // a new result only appears out of the accumulate step
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_ACC))
        else $error("result raised outside accumulate step");

    // a total never shrinks while the block runs
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ACC) && $past(aresetn) |=> (sum_reg >= $past(sum_reg)))
        else $error("total decreased");
`endif

endmodule
